[design/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and defaults for the generational slot pool.
// ----------------------------------------------------------------------------
package gsp_pkg;

   localparam int GSP_SLOTS        = 64;
   localparam int GSP_VERSION_BITS = 32;
   // width of the version fields on the request and response words
   localparam int GSP_VER_W        = 32;

   typedef enum logic [1:0] {
      FUNC_ACQUIRE = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_CHECK   = 2'd2
   } func_type;

endpackage

[design/gsp_table.sv]
// ----------------------------------------------------------------------------
// gsp_table
// Single-port-write, single-read table with registered read data, per-entry
// valid bits (invalid entries read as a supplied default) and forwarding of
// a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module gsp_table #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 38
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [WIDTH-1:0]         rd_dflt,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] raw_ff;
   logic             use_mem_ff;
   logic             use_mem_in;
   logic [WIDTH-1:0] alt_ff;
   logic [WIDTH-1:0] alt_in;
   logic             fwd;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign fwd        = wr_en && (wr_addr == rd_addr);
   assign use_mem_in = !fwd && vld_ff[rd_addr];
   assign alt_in     = fwd ? wr_data : rd_dflt;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_mem_ff <= 1'b0;
      end else if (rd_en) begin
         use_mem_ff <= use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         alt_ff <= alt_in;
      end
   end

   assign rd_data = use_mem_ff ? raw_ff : alt_ff;

endmodule

[design/generational_slot_pool_top.sv]
// ----------------------------------------------------------------------------
// generational_slot_pool_top
// Slot pool handing out (index, version) handles from a ring of free slots.
// ----------------------------------------------------------------------------
// Usage: each request word carries an operation in req_tuser (acquire,
// release or check) and a handle in req_tdata. Every request gives exactly
// one response word: rsp_tuser is the ok flag, rsp_tdata holds the acquired
// slot index and version (zero unless an acquire succeeds) and the number of
// free slots after the operation.
// The csr channel writes the number of active slots (0 taken as 1, values
// above SLOTS as SLOTS) and rebuilds the pool at once; write it only while
// no request is in flight.
// Requests pass through the work stage and then the output register. One
// request is taken every cycle while the receiver takes responses: the
// free ring and the slot table each do one registered read per request,
// issued at acceptance, and at most one write when the request completes,
// with same-cycle writes forwarded. Reset leaves SLOTS active slots, all
// free, all versions zero; no clearing pass is needed. When the receiver
// stalls, the response stays in the output register, one more request is
// held in the work stage, and req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module generational_slot_pool_top #(
   parameter int SLOTS        = gsp_pkg::GSP_SLOTS,
   parameter int VERSION_BITS = gsp_pkg::GSP_VERSION_BITS
) (
   input  logic clock,
   input  logic reset,
   // config: active slot count
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [$clog2(SLOTS+1)-1:0]             csr_data,
   // requests
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: handle_index, handle_version, zero fill
   input  logic [(($clog2(SLOTS)+gsp_pkg::GSP_VER_W+7)/8)*8-1:0] req_tdata,
   // fields from bit 0: func
   input  logic [1:0]                             req_tuser,
   // responses
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // fields from bit 0: slot_index, slot_version, free_count, zero fill
   output logic [(($clog2(SLOTS)+gsp_pkg::GSP_VER_W+$clog2(SLOTS+1)+7)/8)*8-1:0] rsp_tdata,
   // fields from bit 0: ok
   output logic                                   rsp_tuser
);

   import gsp_pkg::*;

   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS+1);
   localparam int RING_W     = IDX_W + VERSION_BITS;
   localparam int SLOT_W     = 1 + VERSION_BITS;
   localparam int RSP_DATA_W = ((IDX_W + GSP_VER_W + CNT_W + 7) / 8) * 8;

   // pool state
   logic [CNT_W-1:0] active_ff;
   logic [CNT_W-1:0] active_in;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // work stage
   logic                 b_valid_ff;
   logic [1:0]           b_func_ff;
   logic [IDX_W-1:0]     b_idx_ff;
   logic [GSP_VER_W-1:0] b_ver_ff;

   // output register
   logic                 o_valid_ff;
   logic                 o_ok_ff;
   logic [IDX_W-1:0]     o_idx_ff;
   logic [GSP_VER_W-1:0] o_ver_ff;
   logic [CNT_W-1:0]     o_cnt_ff;

   logic csr_accept;
   logic req_accept;
   logic b_go;

   logic [RING_W-1:0] ring_rd;
   logic [RING_W-1:0] ring_wdata;
   logic [IDX_W-1:0]  ring_waddr;
   logic              ring_we;
   logic [SLOT_W-1:0] slot_rd;
   logic [SLOT_W-1:0] slot_wdata;
   logic [IDX_W-1:0]  slot_waddr;
   logic              slot_we;

   logic [IDX_W-1:0]        r_slot;
   logic [VERSION_BITS-1:0] r_gen;
   logic [VERSION_BITS-1:0] new_gen;
   logic                    s_busy;
   logic [VERSION_BITS-1:0] s_gen;
   logic                    handle_valid;
   logic                    is_acq;
   logic                    is_rel;
   logic                    is_chk;
   logic                    acq_ok;
   logic                    rel_ok;
   logic                    res_ok;
   logic [CNT_W-1:0]        head_inc;
   logic [IDX_W-1:0]        head_nx;
   logic [CNT_W:0]          pos_sum;
   logic [CNT_W:0]          pos_wrap;

   // ---------------------------------------------------------------- config
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_comb begin
      if (csr_data == '0) begin
         active_in = CNT_W'(1);
      end else if (csr_data > CNT_W'(SLOTS)) begin
         active_in = CNT_W'(SLOTS);
      end else begin
         active_in = csr_data;
      end
   end

   // ---------------------------------------------------------------- handshake
   assign b_go       = b_valid_ff && (!o_valid_ff || rsp_tready);
   assign req_tready = !b_valid_ff || b_go;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- work stage
   assign r_slot = ring_rd[IDX_W-1:0];
   assign r_gen  = ring_rd[RING_W-1:IDX_W];
   assign s_busy = slot_rd[SLOT_W-1];
   assign s_gen  = slot_rd[VERSION_BITS-1:0];

   assign new_gen = r_gen + VERSION_BITS'(1);

   assign is_acq = (b_func_ff == FUNC_ACQUIRE);
   assign is_rel = (b_func_ff == FUNC_RELEASE);
   assign is_chk = (b_func_ff == FUNC_CHECK);

   // handle versions with bits above the stored width never match
   assign handle_valid = (CNT_W'(b_idx_ff) < active_ff) && s_busy
                         && (b_ver_ff == GSP_VER_W'(s_gen));

   assign acq_ok = is_acq && (count_ff != '0);
   assign rel_ok = is_rel && handle_valid && (count_ff < active_ff);
   assign res_ok = acq_ok || rel_ok || (is_chk && handle_valid);

   assign head_inc = CNT_W'(head_ff) + CNT_W'(1);
   assign head_nx  = (head_inc >= active_ff) ? '0 : IDX_W'(head_inc);

   // tail position, one conditional subtract for the ring wrap
   assign pos_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign pos_wrap = (pos_sum >= (CNT_W+1)'(active_ff))
                     ? pos_sum - (CNT_W+1)'(active_ff) : pos_sum;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (b_go && acq_ok) begin
         head_in  = head_nx;
         count_in = count_ff - CNT_W'(1);
      end else if (b_go && rel_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // released slots keep their version in the ring entry
   assign ring_we    = b_go && rel_ok;
   assign ring_waddr = IDX_W'(pos_wrap);
   assign ring_wdata = {s_gen, b_idx_ff};

   assign slot_we    = b_go && (acq_ok || rel_ok);
   assign slot_waddr = acq_ok ? r_slot : b_idx_ff;
   assign slot_wdata = acq_ok ? {1'b1, new_gen} : {1'b0, s_gen};

   gsp_table #(
      .DEPTH (SLOTS),
      .WIDTH (RING_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_accept),
      .rd_en   (req_accept),
      .rd_addr (head_in),
      .rd_dflt (RING_W'(head_in)),
      .rd_data (ring_rd),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata)
   );

   gsp_table #(
      .DEPTH (SLOTS),
      .WIDTH (SLOT_W)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_accept),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[IDX_W-1:0]),
      .rd_dflt ('0),
      .rd_data (slot_rd),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CNT_W'(SLOTS);
         head_ff   <= '0;
         count_ff  <= CNT_W'(SLOTS);
      end else if (csr_accept) begin
         active_ff <= active_in;
         head_ff   <= '0;
         count_ff  <= active_in;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_go) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_func_ff <= req_tuser;
         b_idx_ff  <= req_tdata[IDX_W-1:0];
         b_ver_ff  <= req_tdata[IDX_W+GSP_VER_W-1:IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (b_go) begin
         o_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         o_ok_ff  <= res_ok;
         o_idx_ff <= acq_ok ? r_slot : '0;
         o_ver_ff <= acq_ok ? GSP_VER_W'(new_gen) : '0;
         o_cnt_ff <= count_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser  = o_ok_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_cnt_ff, o_ver_ff, o_idx_ff});

endmodule

[dv/tb_generational_slot_pool_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_slot_pool_top
// Self-checking bench for the slot pool. Acquire, release, check and reserved
// words go through the request stream while a tracker keeps its own copy of
// the free ring and the per-slot busy bits and versions, so it knows each
// response in advance. Responses are compared field by field, in order. The
// pool size is rewritten between phases, including the out-of-range values,
// and the sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_generational_slot_pool_top;
   import gsp_pkg::*;

   localparam int REQ_W         = ((6 + GSP_VER_W + 7) / 8) * 8;
   localparam int RSP_W         = ((6 + GSP_VER_W + 7 + 7) / 8) * 8;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES        = 10;
   localparam int PHASE_WORDS   = 115;

   typedef struct packed {
      logic        ok;
      logic [5:0]  idx;
      logic [31:0] ver;
      logic [6:0]  free;
   } pool_rsp_type;

   class pool_tracker_type;
      logic [5:0]   free_ring [64];
      bit           busy [64];
      logic [31:0]  generation [64];
      int           head;
      int           free_total;
      int           active;
      pool_rsp_type due_responses [$];
      int           mismatches;
      int           checked;
      int           empty_acquires;
      int           freed;
      int           valid_checks;

      function new();
         mismatches     = 0;
         checked        = 0;
         empty_acquires = 0;
         freed          = 0;
         valid_checks   = 0;
         set_active(7'd64);
      endfunction

      // out-of-range sizes are clamped, then the whole pool is rebuilt
      function void set_active(logic [6:0] raw);
         int i;
         active = raw;
         if (active == 0) active = 1;
         if (active > 64) active = 64;
         for (i = 0; i < 64; i++) begin
            free_ring[i]  = i[5:0];
            busy[i]       = 1'b0;
            generation[i] = '0;
         end
         head       = 0;
         free_total = active;
      endfunction

      function bit handle_valid(logic [5:0] idx, logic [31:0] ver);
         return (idx < active) && busy[idx] && (generation[idx] == ver);
      endfunction

      function int pick_busy();
         int i;
         int found [$];
         for (i = 0; i < active; i++)
            if (busy[i]) found = {found, i};
         if (found.size() == 0) return -1;
         return found[$urandom_range(found.size() - 1)];
      endfunction

      function int pending();
         return due_responses.size();
      endfunction

      function void note_request(logic [1:0] f, logic [5:0] idx, logic [31:0] ver);
         pool_rsp_type want;
         int           pos;
         logic [5:0]   s;
         want = '0;
         if (f == FUNC_ACQUIRE) begin
            if (free_total != 0) begin
               s    = free_ring[head];
               head = head + 1;
               if (head >= active) head -= active;
               free_total--;
               busy[s]       = 1'b1;
               generation[s] = generation[s] + 1;
               want.ok  = 1'b1;
               want.idx = s;
               want.ver = generation[s];
            end else begin
               empty_acquires++;
            end
         end else if (f == FUNC_RELEASE) begin
            if (handle_valid(idx, ver) && free_total < active) begin
               pos = head + free_total;
               if (pos >= active) pos -= active;
               busy[idx]      = 1'b0;
               free_ring[pos] = idx;
               free_total++;
               want.ok = 1'b1;
               freed++;
            end
         end else if (f == FUNC_CHECK) begin
            want.ok = handle_valid(idx, ver);
            if (want.ok) valid_checks++;
         end
         want.free = free_total[6:0];
         due_responses = {due_responses, want};
      endfunction

      task report_mismatch(string what, longint unsigned want, longint unsigned got);
         mismatches++;
         $display("mismatch on response %0d: %s expected %0h got %0h",
                  checked, what, want, got);
      endtask

      task check_response(logic ok, logic [5:0] idx, logic [31:0] ver, logic [6:0] free);
         pool_rsp_type want;
         if (due_responses.size() == 0) begin
            report_mismatch("unexpected word", 0, {ok, idx, ver, free});
         end else begin
            want = due_responses.pop_front();
            if (ok !== want.ok) report_mismatch("ok", want.ok, ok);
            if (idx !== want.idx) report_mismatch("slot_index", want.idx, idx);
            if (ver !== want.ver) report_mismatch("slot_version", want.ver, ver);
            if (free !== want.free) report_mismatch("free_count", want.free, free);
         end
         checked++;
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [6:0]       csr_data = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   pool_tracker_type tracker = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int words_sent     = 0;
   int sizes_written  = 0;
   int idle_cycles    = 0;

   generational_slot_pool_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tuser, rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[44:38]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] f, input logic [5:0] idx,
                            input logic [31:0] ver);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {{(REQ_W - 38){1'b0}}, ver, idx};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(f, idx, ver);
      words_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // pool size may only change with nothing in flight
   task automatic write_size(input logic [6:0] raw);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= raw;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_active(raw);
      sizes_written++;
   endtask

   task automatic send_random(input int acq_pct);
      int         r;
      int         b;
      logic [1:0] f;
      logic [5:0] idx;
      logic [31:0] ver;
      r = $urandom_range(99);
      if (r < acq_pct) f = FUNC_ACQUIRE;
      else if (r < acq_pct + ((100 - acq_pct) * 6) / 10) f = FUNC_RELEASE;
      else if (r < 97) f = FUNC_CHECK;
      else f = FUNC_RESERVED;
      idx = 6'($urandom_range(63));
      ver = $urandom;
      b = tracker.pick_busy();
      r = $urandom_range(99);
      // mostly live handles, then stale or idle-slot versions, then noise
      if (r < 60 && b >= 0) begin
         idx = b[5:0];
         ver = tracker.generation[b];
      end else if (r < 80) begin
         ver = tracker.generation[idx] - $urandom_range(1);
      end
      send_word(f, idx, ver);
   endtask

   initial begin
      int ph;
      int n;
      int acq_pct;
      logic [6:0] raw;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset pool of 64
      send_word(FUNC_CHECK, 6'd0, 32'd0);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_CHECK, 6'd0, 32'd1);
      send_word(FUNC_CHECK, 6'd0, 32'd2);
      send_word(FUNC_CHECK, 6'd0, 32'hFFFF_FFFF);
      send_word(FUNC_RELEASE, 6'd0, 32'd0);
      send_word(FUNC_RELEASE, 6'd0, 32'd1);
      send_word(FUNC_RELEASE, 6'd0, 32'd1);
      send_word(FUNC_RESERVED, 6'd63, 32'hFFFF_FFFF);
      send_word(FUNC_ACQUIRE, 6'd63, 32'hFFFF_FFFF);
      send_word(FUNC_CHECK, 6'd63, 32'd0);
      // single slot: empty pool and index beyond the active range
      write_size(7'd1);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_CHECK, 6'd63, 32'd1);
      send_word(FUNC_RELEASE, 6'd0, 32'd1);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      write_size(7'd0);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      write_size(7'h7F);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_CHECK, 6'd63, 32'hFFFF_FFFF);
      // two slots: head wraps and freed slots come back in release order
      write_size(7'd2);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);
      send_word(FUNC_RELEASE, 6'd1, 32'd1);
      send_word(FUNC_RELEASE, 6'd0, 32'd1);
      send_word(FUNC_ACQUIRE, 6'd0, 32'd0);

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         if (ph == 3) raw = 7'd64;
         else if (ph == 6) raw = 7'd0;
         else if (ph == 8) raw = 7'($urandom_range(127, 65));
         else raw = 7'($urandom_range(12, 1));
         write_size(raw);
         acq_pct = $urandom_range(70, 25);
         for (n = 0; n < PHASE_WORDS; n++)
            send_random(acq_pct);
      end

      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d requests over %0d pool sizes, %0d responses checked",
               words_sent, sizes_written, tracker.checked);
      $display("%0d acquires on an empty pool, %0d handles freed, %0d checks found valid",
               tracker.empty_acquires, tracker.freed, tracker.valid_checks);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
